@@ hw/rtl/bli_pkg.sv @@
// shared types, constants and helpers of the band-limited impulse-train unit
`default_nettype none
package bli_pkg;

	localparam int FREQ_W   = 24;
	localparam int SAMPLE_W = 40;
	localparam int PH_W     = 32;
	localparam int ANG_W    = 33;
	localparam int DVD_W    = 48;
	localparam int DVS_W    = 32;
	localparam int FIFO_DEPTH = 2;

	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic signed [34:0] Q30_ONE = 35'sd1073741824;
	localparam logic signed [34:0] INV3F   = 35'sd178956971;
	localparam logic signed [34:0] INV5F   = 35'sd8947849;
	localparam logic signed [34:0] INV7F   = 35'sd213044;
	localparam logic signed [34:0] INV9F   = 35'sd2959;
	localparam logic signed [34:0] INV11F  = 35'sd27;
	localparam logic signed [49:0] SAMPLE_MAX = 50'sd549755813887;
	localparam logic signed [49:0] SAMPLE_MIN = -50'sd549755813888;

	// one sample handed from the front to the back
	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [PH_W-1:0]   phase;
		logic              eob;
	} bli_job_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} bli_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} bli_div_rsp_t;

	// magnitude of a signed 32-bit value
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] m;
		m = v[31] ? 32'(-v) : 32'(v);
		return m;
	endfunction

	// folded remainder of a turn angle for the sine polynomial
	function automatic logic [31:0] sin_fold(input logic [ANG_W-1:0] ang);
		logic [31:0] r;
		r = {1'b0, ang[30:0]};
		if (ang[31])
			r = 32'h8000_0000 - r;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bli_if.sv @@
// item channels of the band-limited impulse-train unit
`default_nettype none
interface bli_in_if;
	logic        valid;
	logic        ready;
	logic [23:0] freq;
	logic [23:0] phase_offset;
	logic        end_of_block;
	modport source(output valid, output freq, output phase_offset, output end_of_block,
		input ready);
	modport sink(input valid, input freq, input phase_offset, input end_of_block,
		output ready);
endinterface

interface bli_out_if;
	logic               valid;
	logic               ready;
	logic signed [39:0] sample;
	logic               end_of_block_out;
	modport source(output valid, output sample, output end_of_block_out, input ready);
	modport sink(input valid, input sample, input end_of_block_out, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bli_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module bli_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bli_pkg::bli_div_req_t req,
	output bli_pkg::bli_div_rsp_t rsp
);
	localparam int CNT_W = $clog2(bli_pkg::DVD_W + 1);

	logic [bli_pkg::DVS_W-1:0] rem_q;
	logic [bli_pkg::DVD_W-1:0] dq_q;
	logic [bli_pkg::DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [bli_pkg::DVS_W:0]   trial;
	logic                      ge;
	logic [bli_pkg::DVS_W-1:0] nrem;

	// trial subtract
	always_comb begin
		trial = {rem_q, dq_q[bli_pkg::DVD_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		nrem  = ge ? bli_pkg::DVS_W'(trial - {1'b0, dvs_q}) : trial[bli_pkg::DVS_W-1:0];
	end

	// iteration control; the dividend shifts out as quotient bits shift in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				rem_q  <= '0;
				dq_q   <= req.dividend;
				dvs_q  <= req.divisor;
				cnt_q  <= CNT_W'(bli_pkg::DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= nrem;
				dq_q  <= {dq_q[bli_pkg::DVD_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;
endmodule
`default_nettype wire

@@ hw/rtl/bli_front.sv @@
// front: takes items, forms the sample phase and advances the accumulator
`default_nettype none
module bli_front #(
	parameter int PHASE_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	bli_in_if.sink            feed,
	input  logic              push_ready,
	output logic              push_valid,
	output bli_pkg::bli_job_t push_job
);
	logic [PHASE_BITS-1:0]        acc_q;
	logic [PHASE_BITS-1:0]        step;
	logic [bli_pkg::FREQ_W-1:0]   f_fix;
	logic [bli_pkg::PH_W-1:0]     acc_ext;

	// zero frequency counts as the smallest step
	assign f_fix = (feed.freq == '0) ? bli_pkg::FREQ_W'(1) : feed.freq;

	generate
		if (PHASE_BITS >= 24) begin : g_wide
			assign step = PHASE_BITS'(f_fix) << (PHASE_BITS - 24);
		end else begin : g_narrow
			assign step = PHASE_BITS'(f_fix >> (24 - PHASE_BITS));
		end
	endgenerate

	// phase as a 32-bit fraction of a turn
	assign acc_ext = bli_pkg::PH_W'(acc_q) << (bli_pkg::PH_W - PHASE_BITS);

	assign feed.ready     = push_ready;
	assign push_valid     = feed.valid;
	assign push_job.freq  = f_fix;
	assign push_job.phase = acc_ext + {feed.phase_offset, 8'd0};
	assign push_job.eob   = feed.end_of_block;

	// phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (feed.valid && push_ready) begin
			acc_q <= acc_q + step;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/bli_fifo.sv @@
// two-entry queue between front and back
`default_nettype none
module bli_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  bli_pkg::bli_job_t push_job,
	output logic              push_ready,
	output logic              pop_valid,
	input  logic              pop_ready,
	output bli_pkg::bli_job_t pop_job
);
	localparam int PTR_W = $clog2(bli_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(bli_pkg::FIFO_DEPTH + 1);

	bli_pkg::bli_job_t mem_q [bli_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != CNT_W'(bli_pkg::FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = mem_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= push_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + 1'b1;
			if (do_pop)
				rp_q <= rp_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/bli_back.sv @@
// back: harmonic count, sines through one shared multiplier, ratio divide, output
`default_nettype none
module bli_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  bli_pkg::bli_job_t pop_job,
	bli_out_if.source         result
);
	typedef enum logic [3:0] {
		S_IDLE, S_DIV1, S_DIV1_W, S_MUL, S_USE, S_DIV2, S_DIV2_W, S_SUM
	} state_t;

	typedef enum logic [3:0] {
		U_ANGH, U_X, U_X2, U_H1, U_H2, U_H3, U_H4, U_H5, U_S, U_C2, U_NUM, U_TERM
	} uop_t;

	typedef enum logic [1:0] {SEL_W, SEL_N, SEL_H} sel_t;

	state_t                      state_q;
	uop_t                        uop_q;
	sel_t                        sel_q;
	bli_pkg::bli_job_t           job_q;
	logic [23:0]                 h_q;
	logic [15:0]                 a_q;
	logic [bli_pkg::ANG_W-1:0]   angh_q;
	logic [1:0]                  quad_q;
	logic [31:0]                 x_q;
	logic [31:0]                 x2_q;
	logic signed [34:0]          acc_q;
	logic signed [31:0]          sw_q;
	logic signed [31:0]          sn_q;
	logic signed [31:0]          ch_q;
	logic signed [31:0]          c2_q;
	logic [47:0]                 nq_q;
	logic signed [17:0]          term_q;
	logic [46:0]                 quo_q;
	logic [31:0]                 opa_q;
	logic [31:0]                 opb_q;
	logic [63:0]                 prod_q;
	logic                        ov_q;
	logic signed [39:0]          sample_q;
	logic                        eob_q;

	bli_pkg::bli_div_req_t       div_req;
	bli_pkg::bli_div_rsp_t       div_rsp;

	logic [bli_pkg::ANG_W-1:0]   nxt_ang;
	logic [32:0]                 pm;
	logic signed [34:0]          hc;
	logic signed [34:0]          acc_new;
	logic [31:0]                 acc_mag;
	logic [30:0]                 smag;
	logic signed [31:0]          s_val;
	logic signed [31:0]          c2_val;
	logic signed [48:0]          ratio;
	logic signed [49:0]          y_sum;
	logic signed [39:0]          y_sat;
	logic                        r_neg;
	logic                        emit;

	bli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// divider requests: 2^39/f first, then the Dirichlet ratio
	always_comb begin
		div_req.start    = (state_q == S_DIV1) || (state_q == S_DIV2);
		div_req.dividend = (state_q == S_DIV1) ? 48'h0080_0000_0000 : nq_q;
		div_req.divisor  = (state_q == S_DIV1) ? 32'(job_q.freq) : bli_pkg::mag32(sw_q);
	end

	// angle of the next sine to start
	always_comb begin
		if (uop_q == U_ANGH)
			nxt_ang = {1'b0, job_q.phase};
		else if (sel_q == SEL_W)
			nxt_ang = angh_q - {1'b0, job_q.phase};
		else
			nxt_ang = angh_q + 33'h0_8000_0000;
	end

	// product post-processing: Horner step, sine finish, double angle
	always_comb begin
		pm = prod_q[62:30];
		case (uop_q)
			U_H1:    hc = bli_pkg::INV9F;
			U_H2:    hc = -bli_pkg::INV7F;
			U_H3:    hc = bli_pkg::INV5F;
			U_H4:    hc = -bli_pkg::INV3F;
			default: hc = bli_pkg::Q30_ONE;
		endcase
		acc_new = hc + (acc_q[34] ? -$signed({2'b00, pm}) : $signed({2'b00, pm}));
		acc_mag = acc_new[34] ? 32'(-acc_new) : 32'(acc_new);
		smag    = (pm > 33'h0_4000_0000) ? 31'h4000_0000 : pm[30:0];
		s_val   = (acc_q[34] ^ quad_q[1]) ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
		c2_val  = $signed({pm[30:0], 1'b0}) - 32'sh4000_0000;
	end

	// ratio and sum with saturation
	always_comb begin
		r_neg = (ch_q[31] ^ sn_q[31]) ^ sw_q[31];
		if (sw_q == '0)
			ratio = ($signed({25'd0, h_q}) - 49'sd1) <<< 16;
		else
			ratio = r_neg ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
		y_sum = 50'(ratio) + 50'(term_q);
		if (y_sum > bli_pkg::SAMPLE_MAX)
			y_sat = 40'(bli_pkg::SAMPLE_MAX);
		else if (y_sum < bli_pkg::SAMPLE_MIN)
			y_sat = 40'(bli_pkg::SAMPLE_MIN);
		else
			y_sat = y_sum[39:0];
	end

	// a finished sample moves into the output register
	assign emit = (state_q == S_SUM) && (!ov_q || result.ready);

	assign pop_ready               = state_q == S_IDLE;
	assign result.valid            = ov_q;
	assign result.sample           = sample_q;
	assign result.end_of_block_out = eob_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			uop_q   <= U_ANGH;
			sel_q   <= SEL_W;
		end else begin
			if (emit)
				ov_q <= 1'b1;
			else if (ov_q && result.ready)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						job_q   <= pop_job;
						state_q <= S_DIV1;
					end
				end
				S_DIV1: state_q <= S_DIV1_W;
				S_DIV1_W: begin
					if (div_rsp.done) begin
						h_q     <= div_rsp.quotient[39:16];
						a_q     <= div_rsp.quotient[15:0];
						opa_q   <= 32'(div_rsp.quotient[39:16]);
						opb_q   <= job_q.phase;
						uop_q   <= U_ANGH;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= 64'(opa_q) * 64'(opb_q);
					state_q <= S_USE;
				end
				S_USE: begin
					state_q <= (uop_q != U_TERM) ? S_MUL : ((sw_q == '0) ? S_SUM : S_DIV2);
					case (uop_q)
						U_ANGH: begin
							angh_q <= prod_q[32:0];
							sel_q  <= SEL_W;
							quad_q <= nxt_ang[32:31];
							opa_q  <= bli_pkg::sin_fold(nxt_ang);
							opb_q  <= bli_pkg::HALF_PI_Q30;
							uop_q  <= U_X;
						end
						U_X: begin
							x_q   <= prod_q[62:31];
							opa_q <= prod_q[62:31];
							opb_q <= prod_q[62:31];
							uop_q <= U_X2;
						end
						U_X2: begin
							x2_q  <= prod_q[61:30];
							acc_q <= -bli_pkg::INV11F;
							opa_q <= prod_q[61:30];
							opb_q <= 32'(bli_pkg::INV11F);
							uop_q <= U_H1;
						end
						U_H1, U_H2, U_H3, U_H4: begin
							acc_q <= acc_new;
							opa_q <= x2_q;
							opb_q <= acc_mag;
							uop_q <= uop_t'(uop_q + 1'b1);
						end
						U_H5: begin
							acc_q <= acc_new;
							opa_q <= x_q;
							opb_q <= acc_mag;
							uop_q <= U_S;
						end
						U_S: begin
							case (sel_q)
								SEL_W: begin
									sw_q   <= s_val;
									sel_q  <= SEL_N;
									quad_q <= nxt_ang[32:31];
									opa_q  <= bli_pkg::sin_fold(nxt_ang);
									opb_q  <= bli_pkg::HALF_PI_Q30;
									uop_q  <= U_X;
								end
								SEL_N: begin
									sn_q   <= s_val;
									sel_q  <= SEL_H;
									quad_q <= nxt_ang[32:31];
									opa_q  <= bli_pkg::sin_fold(nxt_ang);
									opb_q  <= bli_pkg::HALF_PI_Q30;
									uop_q  <= U_X;
								end
								default: begin
									ch_q  <= s_val;
									opa_q <= bli_pkg::mag32(s_val);
									opb_q <= bli_pkg::mag32(s_val);
									uop_q <= U_C2;
								end
							endcase
						end
						U_C2: begin
							c2_q  <= c2_val;
							opa_q <= bli_pkg::mag32(ch_q);
							opb_q <= bli_pkg::mag32(sn_q);
							uop_q <= U_NUM;
						end
						U_NUM: begin
							nq_q  <= prod_q[61:14];
							opa_q <= 32'(a_q);
							opb_q <= bli_pkg::mag32(c2_q);
							uop_q <= U_TERM;
						end
						default: begin
							term_q <= c2_q[31] ? -$signed({1'b0, pm[16:0]})
								: $signed({1'b0, pm[16:0]});
						end
					endcase
				end
				S_DIV2: state_q <= S_DIV2_W;
				S_DIV2_W: begin
					if (div_rsp.done) begin
						quo_q   <= div_rsp.quotient[46:0];
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (emit) begin
						sample_q <= y_sat;
						eob_q    <= job_q.eob;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/band_limited_impulse_train_unit.sv @@
// top level of the band-limited impulse-train oscillator
//
// Band-limited impulse-train oscillator: each item carries a Q0.24 frequency and
// phase offset and yields one signed Q24.16 sample plus the end-of-block flag.
// The front takes an item whenever its two-entry queue has room and advances the
// phase accumulator at once; the back works on one item at a time. Its pace is
// set by the shared restoring divider, used once for the harmonic count and once
// for the Dirichlet ratio (skipped when the base-angle sine is zero), and by the
// single 32x32 multiplier that serves all sine polynomials. A finished sample
// waits in the output register while the back starts the next item.
`default_nettype none
module band_limited_impulse_train_unit #(
	parameter int PHASE_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	bli_in_if.sink    feed,
	bli_out_if.source result
);
	logic              push_valid;
	logic              push_ready;
	bli_pkg::bli_job_t push_job;
	logic              pop_valid;
	logic              pop_ready;
	bli_pkg::bli_job_t pop_job;

	bli_front #(.PHASE_BITS(PHASE_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	bli_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	bli_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.result    (result)
	);
endmodule
`default_nettype wire

@@ hw/rtl/bli_chk.sv @@
// port-level checks of the band-limited impulse-train unit
`default_nettype none
module bli_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [39:0] sample
);
	logic [2:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample))
		else $error("sample changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 3'd0)
		else $error("result without a pending item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more items in flight than the queue and stages hold");
endmodule

bind band_limited_impulse_train_unit bli_chk u_bli_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (feed.valid),
	.in_ready  (feed.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.sample    (result.sample)
);
`default_nettype wire

@@ bench/tb.sv @@
// testbench of the band-limited impulse-train unit: table-driven and random samples
`default_nettype none
module tb;

	localparam int  LIMIT     = 3000000;
	localparam int  N_RANDOM  = 700;
	localparam int  ACC_BITS  = 24;
	localparam longint unsigned ANG_MASK = (64'd1 << 33) - 64'd1;

	// one directed row; known marks an expectation typed in by hand
	typedef struct {
		logic [23:0]        freq;
		logic [23:0]        offset;
		bit                 eob;
		bit                 known;
		logic signed [39:0] sample;
	} row_t;

	typedef struct {
		logic signed [39:0] sample;
		bit                 eob;
	} tone_t;

	logic clk;
	logic arst_n;
	int   cycles;
	int   errors;
	longint unsigned acc_model;
	tone_t tones_due[$];
	bit    quiet;

	bli_in_if  feed();
	bli_out_if result();

	band_limited_impulse_train_unit #(.PHASE_BITS(ACC_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed),
		.result(result)
	);

	// clock and cycle limit
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	function automatic longint unsigned umag(input longint signed v);
		return v < 0 ? longint'(64'd0) - v : v;
	endfunction

	// signed product, magnitude truncated toward zero
	function automatic longint signed tprod(input longint signed a, input longint signed b,
		input int sh);
		longint unsigned m;
		m = (umag(a) * umag(b)) >> sh;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	// sine of a 33-bit turn angle, Q30
	function automatic longint signed turn_sine(input longint unsigned ang);
		longint unsigned q, r;
		longint signed x, x2, c, s;
		ang = ang & ANG_MASK;
		q = ang >> 31;
		r = ang & 64'h7FFF_FFFF;
		if (q[0])
			r = (64'd1 << 31) - r;
		x = longint'((r * 64'd1686629713) >> 31);
		x2 = tprod(x, x, 30);
		c = -longint'(bli_pkg::INV11F);
		c = longint'(bli_pkg::INV9F) + tprod(x2, c, 30);
		c = -longint'(bli_pkg::INV7F) + tprod(x2, c, 30);
		c = longint'(bli_pkg::INV5F) + tprod(x2, c, 30);
		c = -longint'(bli_pkg::INV3F) + tprod(x2, c, 30);
		c = longint'(bli_pkg::Q30_ONE) + tprod(x2, c, 30);
		s = tprod(x, c, 30);
		if (s > longint'(bli_pkg::Q30_ONE))
			s = bli_pkg::Q30_ONE;
		if (s < -longint'(bli_pkg::Q30_ONE))
			s = -longint'(bli_pkg::Q30_ONE);
		return (q >= 2) ? -s : s;
	endfunction

	// next output sample; advances the phase accumulator
	function automatic tone_t next_tone(input logic [23:0] freq, input logic [23:0] offset,
		input bit eob);
		longint unsigned f, h, a, p, num, den;
		longint signed s_w, s_n, c_h, c_2h, y;
		tone_t t;
		f = (freq == 0) ? 64'd1 : 64'(freq);
		h = (64'd1 << 23) / f;
		a = (((64'd1 << 23) % f) << 16) / f;
		p = ((acc_model << (32 - ACC_BITS)) + (64'(offset) << 8)) & 64'hFFFF_FFFF;
		s_w = turn_sine(p);
		s_n = turn_sine((h - 64'd1) * p);
		c_h = turn_sine(h * p + (64'd1 << 31));
		c_2h = 2 * tprod(c_h, c_h, 30) - longint'(bli_pkg::Q30_ONE);
		if (s_w == 0) begin
			y = (longint'(h) - 1) * 65536;
		end else begin
			num = umag(c_h) * umag(s_n);
			den = umag(s_w) << 14;
			y = longint'(num / den);
			if (((c_h < 0) != (s_n < 0)) != (s_w < 0))
				y = -y;
		end
		y += tprod(longint'(a), c_2h, 30);
		if (y > longint'(bli_pkg::SAMPLE_MAX))
			y = bli_pkg::SAMPLE_MAX;
		if (y < longint'(bli_pkg::SAMPLE_MIN))
			y = bli_pkg::SAMPLE_MIN;
		t.sample = y[39:0];
		t.eob = eob;
		acc_model = (acc_model + f) & ((64'd1 << ACC_BITS) - 1);
		return t;
	endfunction

	// drive one item and wait until it is taken
	task automatic send(input logic [23:0] freq, input logic [23:0] offset, input bit eob,
		input bit known, input logic signed [39:0] sample);
		tone_t t;
		if (!quiet && $urandom_range(99) < 20) begin
			feed.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		feed.valid <= 1'b1;
		feed.freq <= freq;
		feed.phase_offset <= offset;
		feed.end_of_block <= eob;
		do @(posedge clk); while (!feed.ready);
		t = next_tone(freq, offset, eob);
		if (known)
			t.sample = sample;
		tones_due.push_back(t);
	endtask

	// receiver: random stalls, compare each item with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (tones_due.size() == 0) begin
					mismatch("sample with no expectation");
				end else begin
					tone_t t;
					t = tones_due.pop_front();
					if (result.sample !== t.sample)
						mismatch($sformatf("sample %0d, predicted %0d",
							result.sample, t.sample));
					if (result.end_of_block_out !== t.eob)
						mismatch($sformatf("end_of_block_out %b, predicted %b",
							result.end_of_block_out, t.eob));
				end
			end
			result.ready <= quiet || ($urandom_range(99) >= 20);
		end
	end

	row_t rows[14];
	logic [23:0] fr, off;
	int pick;

	initial begin
		cycles = 0;
		errors = 0;
		quiet = 1'b0;
		acc_model = 0;
		feed.valid = 1'b0;
		feed.freq = '0;
		feed.phase_offset = '0;
		feed.end_of_block = 1'b0;
		// quarter-rate at zero phase hits the zero-sine limit, then a zero-phase half-rate
		rows = '{
			'{24'h400000, 24'h000000, 1'b0, 1'b1, 40'sd65536},
			'{24'h800000, 24'hC00000, 1'b1, 1'b1, 40'sd0},
			'{24'h000001, 24'h000000, 1'b0, 1'b0, 40'sd0},
			'{24'h000000, 24'hFFFFFF, 1'b1, 1'b0, 40'sd0},
			'{24'hFFFFFF, 24'h123456, 1'b0, 1'b0, 40'sd0},
			'{24'h800001, 24'h800000, 1'b1, 1'b0, 40'sd0},
			'{24'h7FFFFF, 24'h555555, 1'b0, 1'b0, 40'sd0},
			'{24'h000003, 24'hAAAAAA, 1'b1, 1'b0, 40'sd0},
			'{24'h000100, 24'h000001, 1'b0, 1'b0, 40'sd0},
			'{24'h001000, 24'h400000, 1'b0, 1'b0, 40'sd0},
			'{24'h0ABCDE, 24'hFFFFFF, 1'b1, 1'b0, 40'sd0},
			'{24'h200000, 24'h000000, 1'b0, 1'b0, 40'sd0},
			'{24'h555555, 24'h7FFFFF, 1'b1, 1'b0, 40'sd0},
			'{24'h000002, 24'h000000, 1'b0, 1'b0, 40'sd0}
		};
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (rows[i])
			send(rows[i].freq, rows[i].offset, rows[i].eob, rows[i].known, rows[i].sample);

		// random samples, with a stretch free of stalls in the middle
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 300 && i < 420);
			pick = $urandom_range(99);
			if (pick < 60)
				fr = 24'($urandom_range(1, 24'h800000));
			else if (pick < 72)
				fr = 24'($urandom_range(0, 255));
			else if (pick < 84)
				fr = 24'($urandom_range(24'h7FFF00, 24'h800000));
			else
				fr = 24'($urandom_range(24'h800001, 24'hFFFFFF));
			off = 24'($urandom);
			// land on zero phase now and then
			if ($urandom_range(99) < 10)
				off = 24'((64'd1 << 24) - acc_model);
			send(fr, off, 1'($urandom_range(1)), 1'b0, 40'sd0);
		end
		feed.valid <= 1'b0;

		while (tones_due.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
